[rtl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[rtl/frdc_pkg.sv]
// shared constants and types of the flow classifier
package frdc_pkg;
   localparam int FLOW_ENTRIES = 1024;
   localparam int IDX_W = $clog2(FLOW_ENTRIES);
   localparam logic [31:0] CHECK_INTERVAL = 32'(64'd1000000000 >> 24);
   localparam logic [31:0] STALE_LIMIT = 32'((64'd30 * 64'd1000000000) >> 24);
   localparam int AVG_FRAC_BITS = 12;
   localparam logic [7:0] NO_CLASS = 8'hff;
   localparam logic [15:0] COUNT_MAX = 16'hffff;
   localparam logic [2:0] REG_BULK_TRIGGER = 3'd0;
   localparam logic [2:0] REG_BULK_HOLD = 3'd1;
   localparam logic [2:0] REG_BULK_CODE = 3'd2;
   localparam logic [2:0] REG_PRIO_CODE = 3'd3;
   localparam logic [2:0] REG_PRIO_LIMIT = 3'd4;

   typedef struct packed {
      logic [15:0] bulk_trigger_rate;
      logic [7:0]  bulk_hold_intervals;
      logic [7:0]  bulk_code;
      logic [7:0]  prio_code;
      logic [15:0] prio_length_limit;
   } cfg_type;

   // classified request handed from front to back
   typedef struct packed {
      logic        check;
      logic [31:0] flow_key;
      logic [31:0] now_units;
      logic [15:0] packet_length;
      logic [7:0]  class_in;
   } job_type;
endpackage

[rtl/frdc_front.sv]
// front end: decides whether a request needs a flow check, two-entry queue
module frdc_front (
   input  logic             clock,
   input  logic             reset,
   input  frdc_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [31:0]      req_flow_key,
   input  logic [31:0]      req_now_units,
   input  logic [15:0]      req_packet_length,
   input  logic [7:0]       req_class_in,
   input  logic             req_default_marked,
   output logic             job_valid,
   input  logic             job_ready,
   output frdc_pkg::job_type job
);
   import frdc_pkg::*;

   job_type   q_ff [2];
   logic      wr_ff, rd_ff, wr_in, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   job_type   j;
   logic      push, pop;

   always_comb begin
      j.check = req_default_marked &&
                (cfg.bulk_trigger_rate != 16'd0 || cfg.prio_length_limit != 16'd0);
      j.flow_key = req_flow_key;
      j.now_units = (req_now_units == 32'd0) ? 32'd1 : req_now_units;
      j.packet_length = req_packet_length;
      j.class_in = req_class_in;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_ready;
   assign job = q_ff[rd_ff];
   assign wr_in = push ? ~wr_ff : wr_ff;
   assign rd_in = pop ? ~rd_ff : rd_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= j;
   end
endmodule

[rtl/frdc_back.sv]
// back end: flow table read, update and write back, result register
module frdc_back (
   input  logic              clock,
   input  logic              reset,
   input  frdc_pkg::cfg_type cfg,
   input  logic              job_valid,
   output logic              job_ready,
   input  frdc_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_class_out,
   output logic              rsp_flow_found
);
   import frdc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam int ENT_W = 1 + 32 + 32 + 32 + 16 + 8 + 8;

   logic [ENT_W-1:0] mem [FLOW_ENTRIES];
   logic [ENT_W-1:0] rd_ff;
   logic clr_ff;
   logic [IDX_W-1:0] clr_idx_ff;
   logic [1:0] st_ff, st_in;
   job_type j_ff;
   logic rv_ff, rv_in;
   logic [7:0] rc_ff, rc_in;
   logic rf_ff, rf_in;
   logic [IDX_W-1:0] idx, widx;
   logic vld;
   logic [31:0] tag, lt, avg, dlt, smp, avg_n;
   logic [15:0] pc;
   logic [7:0] ec, bl;
   logic fresh, we;
   logic [ENT_W-1:0] wdat, wword;

   assign idx = j_ff.flow_key[IDX_W-1:0];
   assign job_ready = (st_ff == ST_IDLE) && !rv_ff && !clr_ff;

   always_comb begin
      {vld, tag, lt, avg, pc, ec, bl} = rd_ff;
      if (!(vld && tag == j_ff.flow_key)) begin
         lt = '0; avg = '0; pc = '0; ec = '0; bl = '0;
      end
      dlt = j_ff.now_units - lt;
      fresh = 1'b0;
      if (lt == 32'd0 || dlt > STALE_LIMIT) begin
         ec = NO_CLASS; avg = '0; fresh = 1'b1;
      end else if (dlt >= CHECK_INTERVAL) begin
         if (bl != 8'd0) begin
            bl = bl - 8'd1;
            if (bl == 8'd0) ec = NO_CLASS;
         end
         fresh = 1'b1;
      end
      if (fresh) begin
         pc = 16'd1; lt = j_ff.now_units;
      end else begin
         if (pc != COUNT_MAX) pc = pc + 16'd1;
         if (cfg.bulk_trigger_rate != 16'd0 && pc > cfg.bulk_trigger_rate) begin
            ec = cfg.bulk_code; bl = cfg.bulk_hold_intervals;
         end
      end
      smp = {4'd0, j_ff.packet_length, 12'd0};
      avg_n = (avg != 32'd0) ? (32'((33'(avg) * 33'd3) >> 2) + (smp >> 2)) : smp;
      if (cfg.prio_length_limit != 16'd0 && ec != cfg.bulk_code) begin
         avg = avg_n;
         ec = (avg_n[31:AVG_FRAC_BITS] < 20'(cfg.prio_length_limit)) ?
              cfg.prio_code : NO_CLASS;
      end
      wdat = {1'b1, j_ff.flow_key, lt, avg, pc, ec, bl};
   end

   assign we = (st_ff == ST_CALC);
   // single write port, shared with the clearing pass after reset
   assign widx = clr_ff ? clr_idx_ff : idx;
   assign wword = clr_ff ? '0 : wdat;

   always_comb begin
      st_in = st_ff;
      rv_in = rv_ff && !rsp_ready;
      rc_in = rc_ff;
      rf_in = rf_ff;
      case (st_ff)
         ST_IDLE: begin
            if (job_valid && job_ready) begin
               if (job.check) st_in = ST_READ;
               else begin
                  rv_in = 1'b1; rc_in = job.class_in; rf_in = 1'b0;
               end
            end
         end
         ST_READ: st_in = ST_CALC;
         ST_CALC: begin
            st_in = ST_IDLE;
            rv_in = 1'b1;
            rc_in = (ec != NO_CLASS) ? ec : j_ff.class_in;
            rf_in = vld && tag == j_ff.flow_key;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         clr_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
         if (clr_ff) begin
            clr_idx_ff <= clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(FLOW_ENTRIES - 1)) clr_ff <= 1'b0;
         end
      end
      rc_ff <= rc_in;
      rf_ff <= rf_in;
      if (job_valid && job_ready) j_ff <= job;
      if (st_ff == ST_READ) rd_ff <= mem[idx];
      if (clr_ff || we) mem[widx] <= wword;
   end

   assign rsp_valid = rv_ff;
   assign rsp_class_out = rc_ff;
   assign rsp_flow_found = rf_ff;
endmodule

[rtl/flow_rate_dscp_classifier.sv]
// a request without flow check passes the queue, then the response register
// with flow check: queue, table read, update and write back, response register
// the back end takes no new request before the last one is through (read, update, hand-off)
// the back end takes no new request while a response waits
// synchronous active-high reset clears the control registers and queue, then a clearing pass
// over all 1024 entries wipes the table valid bits, during which the back end takes no request
// top level of the flow rate and packet size classifier
module flow_rate_dscp_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_flow_key,
   input  logic [31:0] req_now_units,
   input  logic [15:0] req_packet_length,
   input  logic [7:0]  req_class_in,
   input  logic        req_default_marked,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_class_out,
   output logic        rsp_flow_found
);
   import frdc_pkg::*;
`include "assert_macros.svh"

   cfg_type cfg_ff, cfg_in;
   logic    job_valid, job_ready;
   job_type job;

   // register writes, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_BULK_TRIGGER: cfg_in.bulk_trigger_rate = csr_write_data;
            REG_BULK_HOLD:    cfg_in.bulk_hold_intervals = csr_write_data[7:0];
            REG_BULK_CODE:    cfg_in.bulk_code = csr_write_data[7:0];
            REG_PRIO_CODE:    cfg_in.prio_code = csr_write_data[7:0];
            REG_PRIO_LIMIT:   cfg_in.prio_length_limit = csr_write_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= '0;
      else cfg_ff <= cfg_in;
   end

   // front: classify and queue
   frdc_front u_front (
      .clock, .reset, .cfg(cfg_ff),
      .req_valid, .req_ready, .req_flow_key, .req_now_units,
      .req_packet_length, .req_class_in, .req_default_marked,
      .job_valid, .job_ready, .job
   );

   // back: table update and response
   frdc_back u_back (
      .clock, .reset, .cfg(cfg_ff),
      .job_valid, .job_ready, .job,
      .rsp_valid, .rsp_ready, .rsp_class_out, .rsp_flow_found
   );

   // a waiting response blocks the back end from taking work
   `ASSERT_IMP(a_busy, clock, reset, rsp_valid, !job_ready)
   // after a push with no pop, the queue refuses requests or still holds a job
   `ASSERT_NEXT(a_fill, clock, reset, req_valid && req_ready && !job_ready && job_valid,
      !req_ready || job_valid)
endmodule
